@@ sv/ppue_pkg.sv @@
`timescale 1ns / 1ps
package ppue_pkg;

    localparam int POOL_SIZE_DEF = 1024;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DAMP_BITS     = 16;

    localparam logic [1:0] CMD_SPAWN = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [0:0] REG_WORLD_WIDTH  = 1'b0;
    localparam logic [0:0] REG_WORLD_HEIGHT = 1'b1;
    localparam logic [14:0] WORLD_RESET = 15'd1024;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [9:0]         read_slot;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] orient;
        logic signed [31:0] orient_vel;
        logic [16:0]        vel_damp;
        logic [16:0]        orient_damp;
        logic [15:0]        life_ticks;
    } ppue_in_t;

    typedef struct packed {
        logic               accepted;
        logic [9:0]         slot;
        logic               is_active;
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_vel_x;
        logic signed [31:0] out_vel_y;
        logic signed [31:0] out_orient;
        logic [15:0]        out_life;
    } ppue_out_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] orient;
        logic signed [31:0] orient_vel;
        logic [16:0]        vel_damp;
        logic [16:0]        orient_damp;
        logic [15:0]        life;
    } ppue_slot_t;

endpackage

@@ sv/ppue_store.sv @@
`timescale 1ns / 1ps
module ppue_store
    import ppue_pkg::*;
#(
    parameter int POOL_SIZE = POOL_SIZE_DEF,
    parameter int IDX_W     = $clog2(POOL_SIZE)
) (
    input  logic             aclk,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output logic             rd_flag,
    output ppue_slot_t       rd_data,
    input  logic             flag_we,
    input  logic             data_we,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic             wr_flag,
    input  ppue_slot_t       wr_data
);

    logic       flag_mem [POOL_SIZE];
    ppue_slot_t data_mem [POOL_SIZE];

    always_ff @(posedge aclk) begin
        if (flag_we) begin
            flag_mem[wr_addr] <= wr_flag;
        end
        if (rd_en) begin
            rd_flag <= flag_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (data_we) begin
            data_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= data_mem[rd_addr];
        end
    end

endmodule

@@ sv/particle_pool_update_engine_core.sv @@
`timescale 1ns / 1ps
// Particle pool engine: spawn, tick and read commands on a pool of POOL_SIZE slots kept in
// simple dual-port synchronous memories (one read, one write per cycle). After reset a clearing
// pass empties the active flags; no item is taken until it ends. Spawn reads and checks one slot
// at a time from the cursor until it finds a free slot or has probed all POOL_SIZE. Tick visits
// every slot; an active one also goes through MVX, MVY, MAV, SQX, SQY and WB, where the single
// shared 33x33 multiplier does three damping products and two squares in turn. Read issues one
// memory read and returns the slot's contents. One item is worked on at a time; a new item is
// taken while the previous result waits on the output register.
module particle_pool_update_engine_core
    import ppue_pkg::*;
#(
    parameter int POOL_SIZE = POOL_SIZE_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  ppue_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output ppue_out_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = $clog2(POOL_SIZE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SIZE - 1);
    localparam logic [63:0] SPEED_THR = 64'((64'd1 << (2 * FRAC_BITS)) / 64'd1000000);
    localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;

    localparam logic [3:0] ST_CLR     = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_SP_RD   = 4'd2;
    localparam logic [3:0] ST_SP_CHK  = 4'd3;
    localparam logic [3:0] ST_TK_RD   = 4'd4;
    localparam logic [3:0] ST_TK_CHK  = 4'd5;
    localparam logic [3:0] ST_MVX     = 4'd6;
    localparam logic [3:0] ST_MVY     = 4'd7;
    localparam logic [3:0] ST_MAV     = 4'd8;
    localparam logic [3:0] ST_SQX     = 4'd9;
    localparam logic [3:0] ST_SQY     = 4'd10;
    localparam logic [3:0] ST_WB      = 4'd11;
    localparam logic [3:0] ST_RD_ISS  = 4'd12;
    localparam logic [3:0] ST_RD_DATA = 4'd13;
    localparam logic [3:0] ST_DONE    = 4'd14;

    function automatic logic signed [31:0] sat_wide(input logic signed [65:0] v);
        if (v > 66'(S32_MAX)) begin
            return S32_MAX;
        end else if (v < 66'(S32_MIN)) begin
            return S32_MIN;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] sat_neg(input logic signed [31:0] v);
        return (v == S32_MIN) ? S32_MAX : -v;
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [65:0] s;
        s = 66'(a) + 66'(b);
        return sat_wide(s);
    endfunction

    // arithmetic shift floors, matching round toward minus infinity
    function automatic logic signed [31:0] damp_of(input logic signed [65:0] p);
        return sat_wide(p >>> DAMP_BITS);
    endfunction

    logic [3:0]         state_reg, state_next;
    logic [IDX_W-1:0]   cursor_reg, cursor_next;
    logic [IDX_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    ppue_in_t           in_reg, in_next;
    ppue_out_t          res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    ppue_out_t          m_data_reg, m_data_next;
    logic [14:0]        width_reg, width_next;
    logic [14:0]        height_reg, height_next;
    logic signed [31:0] px_reg, px_next, py_reg, py_next;
    logic signed [31:0] vx_reg, vx_next, vy_reg, vy_next;
    logic signed [31:0] ang_reg, ang_next, av_reg, av_next;
    logic signed [65:0] prod_reg, prod_next;
    logic [63:0]        sq_reg, sq_next;

    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               rd_flag;
    ppue_slot_t         rd_data;
    logic               flag_we, data_we, wr_flag;
    logic [IDX_W-1:0]   wr_addr;
    ppue_slot_t         wr_data;

    logic signed [32:0] mul_a, mul_b;
    logic [47:0]        ex_wide, ey_wide;
    logic signed [31:0] ex, ey;
    logic [64:0]        speed;
    logic               cfg_wr;

    ppue_store #(
        .POOL_SIZE (POOL_SIZE),
        .IDX_W     (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_flag (rd_flag),
        .rd_data (rd_data),
        .flag_we (flag_we),
        .data_we (data_we),
        .wr_addr (wr_addr),
        .wr_flag (wr_flag),
        .wr_data (wr_data)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign prdata  = (paddr[2] == REG_WORLD_HEIGHT) ? {17'd0, height_reg} : {17'd0, width_reg};

    assign ex_wide = 48'(width_reg) << FRAC_BITS;
    assign ey_wide = 48'(height_reg) << FRAC_BITS;
    assign ex = (ex_wide > 48'(S32_MAX)) ? S32_MAX : ex_wide[31:0];
    assign ey = (ey_wide > 48'(S32_MAX)) ? S32_MAX : ey_wide[31:0];
    assign speed = 65'(sq_reg) + 65'(prod_reg[63:0]);

    always_comb begin
        case (state_reg)
            ST_MVX: begin
                mul_a = 33'(vx_reg);
                mul_b = {16'd0, rd_data.vel_damp};
            end
            ST_MVY: begin
                mul_a = 33'(vy_reg);
                mul_b = {16'd0, rd_data.vel_damp};
            end
            ST_MAV: begin
                mul_a = 33'(av_reg);
                mul_b = {16'd0, rd_data.orient_damp};
            end
            ST_SQX: begin
                mul_a = 33'(vx_reg);
                mul_b = 33'(vx_reg);
            end
            default: begin
                mul_a = 33'(vy_reg);
                mul_b = 33'(vy_reg);
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        cursor_next  = cursor_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        in_next      = in_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        vx_next      = vx_reg;
        vy_next      = vy_reg;
        ang_next     = ang_reg;
        av_next      = av_reg;
        prod_next    = mul_a * mul_b;
        sq_next      = sq_reg;
        rd_en        = 1'b0;
        rd_addr      = idx_reg;
        flag_we      = 1'b0;
        data_we      = 1'b0;
        wr_addr      = idx_reg;
        wr_flag      = 1'b0;
        wr_data      = '{pos_x: px_reg, pos_y: py_reg, vel_x: vx_reg, vel_y: vy_reg,
                         orient: ang_reg, orient_vel: av_reg,
                         vel_damp: rd_data.vel_damp, orient_damp: rd_data.orient_damp,
                         life: rd_data.life - 16'd1};

        if (cfg_wr) begin
            if (paddr[2] == REG_WORLD_WIDTH) begin
                width_next = pwdata[14:0];
            end else begin
                height_next = pwdata[14:0];
            end
        end

        case (state_reg)
            ST_CLR: begin
                flag_we = 1'b1;
                if (idx_reg == LAST_IDX) begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    in_next  = s_data;
                    res_next = '0;
                    cnt_next = '0;
                    idx_next = '0;
                    case (s_data.cmd)
                        CMD_SPAWN: state_next = ST_SP_RD;
                        CMD_TICK:  state_next = ST_TK_RD;
                        CMD_READ:  state_next = ST_RD_ISS;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_SP_RD: begin
                rd_en      = 1'b1;
                rd_addr    = cursor_reg;
                state_next = ST_SP_CHK;
            end
            ST_SP_CHK: begin
                cursor_next = (cursor_reg == LAST_IDX) ? '0 : cursor_reg + 1'b1;
                if (!rd_flag) begin
                    flag_we  = 1'b1;
                    data_we  = 1'b1;
                    wr_addr  = cursor_reg;
                    wr_flag  = 1'b1;
                    wr_data  = '{pos_x: in_reg.pos_x, pos_y: in_reg.pos_y,
                                 vel_x: in_reg.vel_x, vel_y: in_reg.vel_y,
                                 orient: in_reg.orient, orient_vel: in_reg.orient_vel,
                                 vel_damp: in_reg.vel_damp, orient_damp: in_reg.orient_damp,
                                 life: in_reg.life_ticks};
                    res_next.accepted = 1'b1;
                    res_next.slot     = 10'(cursor_reg);
                    state_next        = ST_DONE;
                end else if (cnt_reg == LAST_IDX) begin
                    // pool full: the cursor has come round to where it started
                    state_next = ST_DONE;
                end else begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_SP_RD;
                end
            end
            ST_TK_RD: begin
                rd_en      = 1'b1;
                state_next = ST_TK_CHK;
            end
            ST_TK_CHK: begin
                if (!rd_flag) begin
                    if (idx_reg == LAST_IDX) begin
                        res_next.accepted = 1'b1;
                        state_next        = ST_DONE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_TK_RD;
                    end
                end else begin
                    px_next  = rd_data.pos_x;
                    py_next  = rd_data.pos_y;
                    vx_next  = rd_data.vel_x;
                    vy_next  = rd_data.vel_y;
                    ang_next = rd_data.orient;
                    av_next  = rd_data.orient_vel;
                    // clamp to the world box and bounce off the crossed edge
                    if (rd_data.pos_x < 0) begin
                        px_next = '0;
                        vx_next = sat_neg(rd_data.vel_x);
                    end else if (rd_data.pos_x > ex) begin
                        px_next = ex;
                        vx_next = sat_neg(rd_data.vel_x);
                    end
                    if (rd_data.pos_y < 0) begin
                        py_next = '0;
                        vy_next = sat_neg(rd_data.vel_y);
                    end else if (rd_data.pos_y > ey) begin
                        py_next = ey;
                        vy_next = sat_neg(rd_data.vel_y);
                    end
                    state_next = ST_MVX;
                end
            end
            ST_MVX: begin
                state_next = ST_MVY;
            end
            ST_MVY: begin
                vx_next    = damp_of(prod_reg);
                state_next = ST_MAV;
            end
            ST_MAV: begin
                vy_next    = damp_of(prod_reg);
                state_next = ST_SQX;
            end
            ST_SQX: begin
                av_next    = damp_of(prod_reg);
                px_next    = sat_add(px_reg, vx_reg);
                state_next = ST_SQY;
            end
            ST_SQY: begin
                sq_next    = prod_reg[63:0];
                py_next    = sat_add(py_reg, vy_reg);
                ang_next   = sat_add(ang_reg, av_reg);
                state_next = ST_WB;
            end
            ST_WB: begin
                flag_we = 1'b1;
                data_we = 1'b1;
                wr_flag = !((rd_data.life == 16'd0) || (speed <= 65'(SPEED_THR)));
                if (idx_reg == LAST_IDX) begin
                    res_next.accepted = 1'b1;
                    state_next        = ST_DONE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_TK_RD;
                end
            end
            ST_RD_ISS: begin
                rd_en      = 1'b1;
                rd_addr    = IDX_W'(in_reg.read_slot);
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                res_next.accepted = 1'b1;
                res_next.slot     = in_reg.read_slot;
                if (32'(in_reg.read_slot) < 32'(POOL_SIZE)) begin
                    res_next.is_active  = rd_flag;
                    res_next.out_pos_x  = rd_data.pos_x;
                    res_next.out_pos_y  = rd_data.pos_y;
                    res_next.out_vel_x  = rd_data.vel_x;
                    res_next.out_vel_y  = rd_data.vel_y;
                    res_next.out_orient = rd_data.orient;
                    res_next.out_life   = rd_data.life;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR;
            cursor_reg  <= '0;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
            width_reg   <= WORLD_RESET;
            height_reg  <= WORLD_RESET;
        end else begin
            state_reg   <= state_next;
            cursor_reg  <= cursor_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg     <= in_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        vx_reg     <= vx_next;
        vy_reg     <= vy_next;
        ang_reg    <= ang_next;
        av_reg     <= av_next;
        prod_reg   <= prod_next;
        sq_reg     <= sq_next;
    end

`ifndef SYNTHESIS
    a_wr_states: assert property (@(posedge aclk) disable iff (!aresetn)
        flag_we |-> (state_reg == ST_CLR || state_reg == ST_SP_CHK || state_reg == ST_WB))
        else $error("pool write outside a write state");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item taken while one is in work");

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cursor_reg) < 32'(POOL_SIZE))
        else $error("spawn cursor beyond pool");

    a_done_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && (!m_valid_reg || m_ready)) |=> (m_valid && s_ready))
        else $error("finished item not handed to output");
`endif

endmodule
